// ----- src/fan_on_off_hysteresis_timer_assert.svh -----
// Assertion macros for the fan on/off hysteresis timer.
// Used by modules that check their own logic; expects clk and rst in scope.
`ifndef FAN_ON_OFF_HYSTERESIS_TIMER_ASSERT_SVH
`define FAN_ON_OFF_HYSTERESIS_TIMER_ASSERT_SVH

// same-cycle implication
`define FOHHT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FOHHT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/fohht_pkg.sv -----
// Package for the fan on/off hysteresis timer: payload, config and result types,
// register indexes and reset values. No dependencies.
package fohht_pkg;

  localparam int unsigned DUTY_W = 10;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned DLY_W  = 24;
  localparam int unsigned IDX_W  = 2;

  typedef enum logic [IDX_W-1:0] {
    REG_DUTY_THRESHOLD  = 2'd0,
    REG_TURN_OFF_DELAY  = 2'd1,
    REG_MIN_OFF_TIME    = 2'd2,
    REG_MIN_DEMAND_TIME = 2'd3
  } reg_idx_t;

  localparam logic [DUTY_W-1:0] RST_DUTY_THRESHOLD  = 10'd500;
  localparam logic [DLY_W-1:0]  RST_TURN_OFF_DELAY  = 24'd5000;
  localparam logic [DLY_W-1:0]  RST_MIN_OFF_TIME    = 24'd5000;
  localparam logic [DLY_W-1:0]  RST_MIN_DEMAND_TIME = 24'd2000;

  typedef struct packed {
    logic [DUTY_W-1:0] duty_threshold;
    logic [DLY_W-1:0]  turn_off_delay;
    logic [DLY_W-1:0]  min_off_time;
    logic [DLY_W-1:0]  min_demand_time;
  } cfg_t;

  typedef struct packed {
    logic [TIME_W-1:0] now_ms;
    logic [DUTY_W-1:0] first_duty;
    logic [DUTY_W-1:0] second_duty;
  } upd_t;

  typedef struct packed {
    logic fan_on;
    logic cooling_needed;
  } result_t;

endpackage

// ----- src/fohht_ifs.sv -----
// Valid/ready channel interfaces for updates and results.
// Depends on fohht_pkg for field widths.
interface fohht_upd_if;
  import fohht_pkg::*;
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] now_ms;
  logic [DUTY_W-1:0] first_duty;
  logic [DUTY_W-1:0] second_duty;

  modport source (output valid, now_ms, first_duty, second_duty, input ready);
  modport sink   (input valid, now_ms, first_duty, second_duty, output ready);
endinterface

interface fohht_res_if;
  logic valid;
  logic ready;
  logic fan_on;
  logic cooling_needed;

  modport source (output valid, fan_on, cooling_needed, input ready);
  modport sink   (input valid, fan_on, cooling_needed, output ready);
endinterface

// ----- src/fohht_cfg_regs.sv -----
// Configuration register bank of the fan hysteresis timer.
// Depends on fohht_pkg.
module fohht_cfg_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [fohht_pkg::IDX_W-1:0] cfg_index,
  input  logic [fohht_pkg::DLY_W-1:0] cfg_data,
  output fohht_pkg::cfg_t            cfg
);
  import fohht_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.duty_threshold  <= RST_DUTY_THRESHOLD;
      cfg.turn_off_delay  <= RST_TURN_OFF_DELAY;
      cfg.min_off_time    <= RST_MIN_OFF_TIME;
      cfg.min_demand_time <= RST_MIN_DEMAND_TIME;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_DUTY_THRESHOLD:  cfg.duty_threshold  <= cfg_data[DUTY_W-1:0];
        REG_TURN_OFF_DELAY:  cfg.turn_off_delay  <= cfg_data;
        REG_MIN_OFF_TIME:    cfg.min_off_time    <= cfg_data;
        REG_MIN_DEMAND_TIME: cfg.min_demand_time <= cfg_data;
      endcase
    end
  end

endmodule

// ----- src/fohht_ctrl.sv -----
// Fan decision logic and timer state: demand detection, stop and start timers.
// Depends on fohht_pkg and fan_on_off_hysteresis_timer_assert.svh.
`include "fan_on_off_hysteresis_timer_assert.svh"

module fohht_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  fohht_pkg::cfg_t     cfg,
  input  logic                step,
  input  fohht_pkg::upd_t     upd,
  output fohht_pkg::result_t  res
);
  import fohht_pkg::*;

  logic              running;
  logic              demand;
  logic [TIME_W-1:0] demand_start_time;
  logic [TIME_W-1:0] last_over_time;
  logic [TIME_W-1:0] stopped_time;

  logic              need;
  logic              stop;
  logic              start;
  logic              running_next;
  logic [TIME_W-1:0] demand_start_time_next;
  logic [TIME_W-1:0] last_over_time_next;
  logic [TIME_W-1:0] stopped_time_next;
  logic [TIME_W-1:0] since_over;
  logic [TIME_W-1:0] since_stop;
  logic [TIME_W-1:0] since_demand;

  always_comb begin
    need = (upd.first_duty > cfg.duty_threshold) || (upd.second_duty > cfg.duty_threshold);
    demand_start_time_next = (need && !demand) ? upd.now_ms : demand_start_time;
    last_over_time_next    = need ? upd.now_ms : last_over_time;

    since_over = upd.now_ms - last_over_time_next;
    stop = running && !need && (upd.first_duty == '0) && (upd.second_duty == '0)
        && (since_over > {{(TIME_W-DLY_W){1'b0}}, cfg.turn_off_delay});
    stopped_time_next = stop ? upd.now_ms : stopped_time;

    since_stop   = upd.now_ms - stopped_time_next;
    since_demand = upd.now_ms - demand_start_time_next;
    start = !(running && !stop) && need
        && (since_stop > {{(TIME_W-DLY_W){1'b0}}, cfg.min_off_time})
        && (since_demand > {{(TIME_W-DLY_W){1'b0}}, cfg.min_demand_time});

    running_next = (running && !stop) || start;

    res.fan_on         = running_next;
    res.cooling_needed = need;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running           <= 1'b0;
      demand            <= 1'b0;
      demand_start_time <= '0;
      last_over_time    <= '0;
      stopped_time      <= '0;
    end else if (step) begin
      running           <= running_next;
      demand            <= need;
      demand_start_time <= demand_start_time_next;
      last_over_time    <= last_over_time_next;
      stopped_time      <= stopped_time_next;
    end
  end

  `FOHHT_ASSERT_NOW(a_no_start_stop, step, !(start && stop), "start and stop in one update")
  `FOHHT_ASSERT_NEXT(a_stop_stamp, step && stop, !running && stopped_time == $past(upd.now_ms),
    "stop did not record time")
  `FOHHT_ASSERT_NEXT(a_demand_stamp, step && need && !demand,
    demand && demand_start_time == $past(upd.now_ms), "demand rise not recorded")
  `FOHHT_ASSERT_NEXT(a_hold, !step, $stable(running) && $stable(stopped_time),
    "state changed without an update")

endmodule

// ----- src/fan_on_off_hysteresis_timer.sv -----
// Fan on/off controller with hysteresis timers: top level.
// Depends on fohht_pkg, fohht_ifs, fohht_cfg_regs and fohht_ctrl.
//
// Usage:
//   upd carries one control update per beat (now_ms, first_duty, second_duty);
//   res returns exactly one beat per update (fan_on, cooling_needed), in order.
//   Configuration is written through cfg_we/cfg_index/cfg_data, index 0..3 =
//   duty threshold, turn-off delay, minimum off time, minimum demand time;
//   write only while no update is in flight.
// Timing:
//   An accepted update is captured in the input register; the decision is
//   made there and lands in the result register, from which res presents
//   it. One update per cycle is sustained while res.ready stays high: the
//   timer state is updated in the same cycle the result is registered.
// Reset (rst, synchronous): fan off, no demand, all timestamps zero, registers
//   back to 500 / 5000 / 5000 / 2000.
// Stall: while res is held, the result register keeps its beat and the input
//   register can still take one more update before upd.ready drops.
module fan_on_off_hysteresis_timer (
  input  logic                        clk,
  input  logic                        rst,
  fohht_upd_if.sink                   upd,
  fohht_res_if.source                 res,
  input  logic                        cfg_we,
  input  logic [fohht_pkg::IDX_W-1:0] cfg_index,
  input  logic [fohht_pkg::DLY_W-1:0] cfg_data
);
  import fohht_pkg::*;

  cfg_t    cfg;
  upd_t    s1;
  logic    s1_valid;
  result_t out;
  logic    out_valid;
  result_t res_next;
  logic    advance;
  logic    step;
  logic    take;

  fohht_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  fohht_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .step (step),
    .upd  (s1),
    .res  (res_next)
  );

  assign advance   = !out_valid || res.ready;
  assign step      = s1_valid && advance;
  assign upd.ready = !s1_valid || advance;
  assign take      = upd.valid && upd.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= take || (s1_valid && !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1.now_ms      <= upd.now_ms;
      s1.first_duty  <= upd.first_duty;
      s1.second_duty <= upd.second_duty;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= step || (out_valid && !res.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out <= res_next;
    end
  end

  assign res.valid          = out_valid;
  assign res.fan_on         = out.fan_on;
  assign res.cooling_needed = out.cooling_needed;

endmodule
